// ----- design/phjc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package phjc_pkg;

   localparam int MAX_PART_BITS   = 3;
   localparam int MAX_BUCKET_BITS = 9;
   localparam int PART_COUNT      = 1 << MAX_PART_BITS;
   localparam int PART_SLOTS      = 1 << MAX_BUCKET_BITS;
   localparam int STORE_BITS      = MAX_PART_BITS + MAX_BUCKET_BITS;
   localparam int STORE_DEPTH     = 1 << STORE_BITS;

   localparam int KEY_WIDTH       = 32;
   localparam int FILL_WIDTH      = MAX_BUCKET_BITS + 1;
   localparam int COUNT_WIDTH     = 9;
   localparam int TOTAL_WIDTH     = 64;
   localparam int STATUS_WIDTH    = 2;
   localparam int PBITS_WIDTH     = 2;
   localparam int BBITS_WIDTH     = 4;
   localparam int CSR_DATA_WIDTH  = 4;

   localparam logic [KEY_WIDTH-1:0] MIX_C1 = 32'h85eb_ca6b;
   localparam logic [KEY_WIDTH-1:0] MIX_C2 = 32'hc2b2_ae35;

   localparam logic [STATUS_WIDTH-1:0] STATUS_INSERTED = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_PROBED   = 2'd2;

   localparam logic REQ_BUILD = 1'b0;
   localparam logic REQ_PROBE = 1'b1;

   localparam logic CSR_PART_BITS   = 1'b0;
   localparam logic CSR_BUCKET_BITS = 1'b1;

   typedef struct packed {
      logic [KEY_WIDTH-1:0]       key;
      logic [MAX_BUCKET_BITS-1:0] link;
   } entry_type;

   localparam int ENTRY_WIDTH = $bits(entry_type);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_LOOKUP,
      ST_HEAD,
      ST_WALK,
      ST_RESULT
   } phjc_state_type;

endpackage

`default_nettype wire

// ----- design/phjc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module phjc_ram #(
   parameter int WIDTH     = 32,
   parameter int ADDR_BITS = 12
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [1 << ADDR_BITS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- design/phjc_hash.sv -----
`timescale 1ns / 1ps
`default_nettype none

module phjc_hash
   import phjc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 load,
   input  wire logic [KEY_WIDTH-1:0] key,
   output logic      [KEY_WIDTH-1:0] hash
);

   logic [KEY_WIDTH-1:0] h0;
   logic [KEY_WIDTH-1:0] h1;
   logic [KEY_WIDTH-1:0] prod1_in;
   logic [KEY_WIDTH-1:0] prod1_ff;
   logic [KEY_WIDTH-1:0] prod2_in;
   logic [KEY_WIDTH-1:0] prod2_ff;

   always_comb begin
      h0       = key ^ (key >> 16);
      prod1_in = h0 * MIX_C1;
      h1       = prod1_ff ^ (prod1_ff >> 13);
      prod2_in = h1 * MIX_C2;
      hash     = prod2_ff ^ (prod2_ff >> 16);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod1_ff <= prod1_in;
      end
      prod2_ff <= prod2_in;
   end

endmodule

`default_nettype wire

// ----- design/partitioned_hash_join_count.sv -----
// Chained hash join engine with a build and a probe operation. After reset the block sweeps the
// bucket head memory clear, one entry per cycle, over all 4096 entries; req_stall stays high
// during that pass while configuration writes are taken as ever. Items are then handled one at a
// time. A build item passes from acceptance to the result register through the registered hash
// multipliers, a head memory read and a write-back that is skipped when the partition is full.
// A probe item reads the head and then walks the selected chain, and the walk issues one read of
// the entry memory per cycle. The next item is accepted in the cycle after the result register is
// loaded. A finished result waits in the output register, and the next item is accepted while it
// is still stalled.
`timescale 1ns / 1ps
`default_nettype none

module partitioned_hash_join_count
   import phjc_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic                      req_type,
   input  wire logic [KEY_WIDTH-1:0]      req_key,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic      [STATUS_WIDTH-1:0]   rsp_status,
   output logic      [COUNT_WIDTH-1:0]    rsp_match_count,
   output logic      [TOTAL_WIDTH-1:0]    rsp_total_matches,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic                      csr_index,
   input  wire logic [CSR_DATA_WIDTH-1:0] csr_data
);

   phjc_state_type state_ff, state_in;

   logic [STORE_BITS-1:0]      clr_cnt_ff, clr_cnt_in;
   logic                       type_ff, type_in;
   logic [KEY_WIDTH-1:0]       key_ff, key_in;
   logic [MAX_PART_BITS-1:0]   part_ff, part_in;
   logic [STORE_BITS-1:0]      hidx_ff, hidx_in;
   logic [COUNT_WIDTH-1:0]     count_ff, count_in;
   logic [STATUS_WIDTH-1:0]    status_ff, status_in;
   logic [TOTAL_WIDTH-1:0]     total_ff, total_in;
   logic [FILL_WIDTH-1:0]      fill_ff [PART_COUNT];
   logic [FILL_WIDTH-1:0]      fill_in [PART_COUNT];
   logic [PBITS_WIDTH-1:0]     pbits_ff, pbits_in;
   logic [BBITS_WIDTH-1:0]     bbits_ff, bbits_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_WIDTH-1:0]    rsp_status_ff, rsp_status_in;
   logic [COUNT_WIDTH-1:0]     rsp_count_ff, rsp_count_in;
   logic [TOTAL_WIDTH-1:0]     rsp_total_ff, rsp_total_in;

   logic                       accept;
   logic                       hash_load;
   logic [KEY_WIDTH-1:0]       hash;
   logic [PBITS_WIDTH-1:0]     pb;
   logic [BBITS_WIDTH-1:0]     bb;
   logic [MAX_PART_BITS-1:0]   part_sel_mask;
   logic [MAX_BUCKET_BITS-1:0] bucket_mask;
   logic [KEY_WIDTH-1:0]       hash_shifted;
   logic [MAX_PART_BITS-1:0]   hash_part;
   logic [MAX_BUCKET_BITS-1:0] hash_bucket;
   logic [FILL_WIDTH-1:0]      fill_pos;
   logic [TOTAL_WIDTH:0]       total_sum;
   logic [TOTAL_WIDTH-1:0]     total_next;
   logic                       result_load;

   logic                       head_wr_en;
   logic [STORE_BITS-1:0]      head_wr_addr;
   logic [MAX_BUCKET_BITS-1:0] head_wr_data;
   logic                       head_rd_en;
   logic [MAX_BUCKET_BITS-1:0] head_rd_data;

   logic                       entry_wr_en;
   logic [STORE_BITS-1:0]      entry_wr_addr;
   entry_type                  entry_wr_data;
   logic                       entry_rd_en;
   logic [STORE_BITS-1:0]      entry_rd_addr;
   entry_type                  entry_rd_data;

   phjc_hash u_hash (
      .clock (clock),
      .load  (hash_load),
      .key   (req_key),
      .hash  (hash)
   );

   phjc_ram #(
      .WIDTH     (MAX_BUCKET_BITS),
      .ADDR_BITS (STORE_BITS)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_wr_en),
      .wr_addr (head_wr_addr),
      .wr_data (head_wr_data),
      .rd_en   (head_rd_en),
      .rd_addr (hidx_in),
      .rd_data (head_rd_data)
   );

   phjc_ram #(
      .WIDTH     (ENTRY_WIDTH),
      .ADDR_BITS (STORE_BITS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_wr_en),
      .wr_addr (entry_wr_addr),
      .wr_data (entry_wr_data),
      .rd_en   (entry_rd_en),
      .rd_addr (entry_rd_addr),
      .rd_data (entry_rd_data)
   );

   assign req_stall         = (state_ff != ST_IDLE);
   assign accept            = req_valid && !req_stall;
   assign hash_load         = accept;
   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_match_count   = rsp_count_ff;
   assign rsp_total_matches = rsp_total_ff;

   always_comb begin
      pb            = (pbits_ff > PBITS_WIDTH'(MAX_PART_BITS)) ?
                      PBITS_WIDTH'(MAX_PART_BITS) : pbits_ff;
      bb            = (bbits_ff > BBITS_WIDTH'(MAX_BUCKET_BITS)) ?
                      BBITS_WIDTH'(MAX_BUCKET_BITS) : bbits_ff;
      part_sel_mask = ~({MAX_PART_BITS{1'b1}} << pb);
      bucket_mask   = ~({MAX_BUCKET_BITS{1'b1}} << bb);
      hash_shifted  = hash >> pb;
      hash_part     = hash[MAX_PART_BITS-1:0] & part_sel_mask;
      hash_bucket   = hash_shifted[MAX_BUCKET_BITS-1:0] & bucket_mask;
      fill_pos      = fill_ff[part_ff];
      total_sum     = {1'b0, total_ff} + (TOTAL_WIDTH + 1)'(count_ff);
      total_next    = total_sum[TOTAL_WIDTH] ? {TOTAL_WIDTH{1'b1}} : total_sum[TOTAL_WIDTH-1:0];
      result_load   = (state_ff == ST_RESULT) && (!rsp_valid_ff || !rsp_stall);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == {STORE_BITS{1'b1}}) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_HASH;
            end
         end
         ST_HASH: begin
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            if (type_ff == REQ_PROBE && head_rd_data != '0) begin
               state_in = ST_WALK;
            end else begin
               state_in = ST_RESULT;
            end
         end
         ST_WALK: begin
            if (entry_rd_data.link == '0) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (result_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      clr_cnt_in    = clr_cnt_ff;
      type_in       = type_ff;
      key_in        = key_ff;
      part_in       = part_ff;
      hidx_in       = hidx_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      total_in      = total_ff;
      fill_in       = fill_ff;
      pbits_in      = pbits_ff;
      bbits_in      = bbits_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_total_in  = rsp_total_ff;

      head_wr_en    = 1'b0;
      head_wr_addr  = hidx_ff;
      head_wr_data  = fill_pos[MAX_BUCKET_BITS-1:0];
      head_rd_en    = 1'b0;
      entry_wr_en   = 1'b0;
      entry_wr_addr = {part_ff, fill_pos[MAX_BUCKET_BITS-1:0]};
      entry_wr_data = '{key: key_ff, link: head_rd_data};
      entry_rd_en   = 1'b0;
      entry_rd_addr = {part_ff, entry_rd_data.link};

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PART_BITS: begin
               pbits_in = csr_data[PBITS_WIDTH-1:0];
            end
            CSR_BUCKET_BITS: begin
               bbits_in = csr_data[BBITS_WIDTH-1:0];
            end
            default: begin
               pbits_in = pbits_ff;
            end
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            head_wr_en   = 1'b1;
            head_wr_addr = clr_cnt_ff;
            head_wr_data = '0;
            clr_cnt_in   = clr_cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (accept) begin
               type_in  = req_type;
               key_in   = req_key;
               count_in = '0;
            end
         end
         ST_LOOKUP: begin
            part_in    = hash_part;
            hidx_in    = {hash_part, hash_bucket};
            head_rd_en = 1'b1;
         end
         ST_HEAD: begin
            if (type_ff == REQ_BUILD) begin
               if (fill_pos >= FILL_WIDTH'(PART_SLOTS)) begin
                  status_in = STATUS_FULL;
               end else begin
                  status_in        = STATUS_INSERTED;
                  head_wr_en       = 1'b1;
                  entry_wr_en      = 1'b1;
                  fill_in[part_ff] = fill_pos + 1'b1;
               end
            end else begin
               status_in     = STATUS_PROBED;
               entry_rd_en   = (head_rd_data != '0);
               entry_rd_addr = {part_ff, head_rd_data};
            end
         end
         ST_WALK: begin
            if (entry_rd_data.key == key_ff) begin
               count_in = count_ff + 1'b1;
            end
            entry_rd_en = (entry_rd_data.link != '0);
         end
         ST_RESULT: begin
            if (result_load) begin
               total_in      = total_next;
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = count_ff;
               rsp_total_in  = total_next;
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         total_ff     <= '0;
         pbits_ff     <= '0;
         bbits_ff     <= BBITS_WIDTH'(MAX_BUCKET_BITS);
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PART_COUNT; i++) begin
            fill_ff[i] <= FILL_WIDTH'(1);
         end
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         total_ff     <= total_in;
         pbits_ff     <= pbits_in;
         bbits_ff     <= bbits_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      key_ff        <= key_in;
      part_ff       <= part_in;
      hidx_ff       <= hidx_in;
      count_ff      <= count_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_total_ff  <= rsp_total_in;
   end

endmodule

`default_nettype wire
